// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

    // Command codes on the request channel; any other code means no command
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SETUP      = 2'd0;
    localparam logic [1:0] CFG_HIGH       = 2'd1;
    localparam logic [1:0] CFG_START_STOP = 2'd2;

    localparam int CFG_DATA_W = 16;

    // Register values after reset
    localparam logic [CFG_DATA_W-1:0] SETUP_RESET      = 16'd5;
    localparam logic [CFG_DATA_W-1:0] HIGH_RESET       = 16'd10;
    localparam logic [CFG_DATA_W-1:0] START_STOP_RESET = 16'd10;

    // Line phases of a sequence
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // Number of data bits in a byte slot; the ack slot follows
    localparam logic [3:0] LAST_DATA_BIT = 4'd8;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       nack_level;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/i2c_master_bit_engine_core.sv =====
// I2C master bit engine: command sequencer, line drive and result skid stage.
`default_nettype none

// Each request is one timing tick of the bus sequencer and may carry a
// command (start, stop, write byte, read byte); a command is taken only
// while the engine is idle. One request is accepted per clock cycle while
// cmd_ready is high. The result channel has an output register plus a
// one-entry skid stage, so cmd_ready only drops while both hold unread
// results. Phase lengths come from the three configuration
// registers (writes are always accepted and must only happen while idle);
// a zero length acts as one tick and lengths beyond COUNT_WIDTH saturate.
module i2c_master_bit_engine_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire i2cm_pkg::req_t    cmd,
    // result channel
    output logic                   res_valid,
    input  wire logic              res_ready,
    output i2cm_pkg::res_t         res,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import i2cm_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] setup_reg, high_reg, start_stop_reg;

    // Sequencer state
    op_t                    op_reg, op_next;
    logic [1:0]             phase_reg, phase_next;
    logic [3:0]             bit_reg, bit_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_reg, ack_next;
    logic                   nack_reg, nack_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   done_next;

    // Result stages
    logic out_valid_reg, skid_valid_reg;
    res_t out_data_reg, skid_data_reg;
    res_t res_next;

    logic                   accept;
    logic [CFG_DATA_W-1:0]  len_raw;
    logic [COUNT_WIDTH-1:0] len_sat;
    logic [COUNT_WIDTH-1:0] tick_inc;

    // Line levels on entry to a phase: {scl, sda}
    function automatic logic [1:0] enter_phase(
        input op_t        op,
        input logic [1:0] ph,
        input logic [3:0] bidx,
        input logic [7:0] shv,
        input logic       nack,
        input logic       scl,
        input logic       sda
    );
        logic scl_o;
        logic sda_o;
        scl_o = scl;
        sda_o = sda;
        if (op == OP_START) begin
            if (ph == PH_FIRST) begin
                sda_o = 1'b1;
                scl_o = 1'b1;
            end
            else if (ph == PH_SECOND) begin
                sda_o = 1'b0;
            end
            else begin
                scl_o = 1'b0;
            end
        end
        else if (op == OP_STOP) begin
            if (ph == PH_FIRST) begin
                sda_o = 1'b0;
            end
            else if (ph == PH_SECOND) begin
                scl_o = 1'b1;
            end
            else begin
                sda_o = 1'b1;
            end
        end
        else begin
            if (ph == PH_FIRST) begin
                if (bidx < LAST_DATA_BIT) begin
                    sda_o = (op == OP_WRITE) ? shv[7] : 1'b1;
                end
                else begin
                    sda_o = (op == OP_WRITE) ? 1'b1 : nack;
                end
            end
            else if (ph == PH_SECOND) begin
                scl_o = 1'b1;
            end
            else begin
                scl_o = 1'b0;
            end
        end
        return {scl_o, sda_o};
    endfunction

    assign cmd_ready = !skid_valid_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // Length of the current phase, saturated to the counter and at least one
    always_comb
    begin
        if (op_reg == OP_START || op_reg == OP_STOP) begin
            len_raw = start_stop_reg;
        end
        else if (phase_reg == PH_SECOND) begin
            len_raw = high_reg;
        end
        else begin
            len_raw = setup_reg;
        end
        if (32'(len_raw) > 32'(CNT_MAX)) begin
            len_sat = CNT_MAX;
        end
        else begin
            len_sat = COUNT_WIDTH'(len_raw);
        end
        if (len_sat == '0) begin
            len_sat = CNT_ONE;
        end
    end

    assign tick_inc = tick_reg + CNT_ONE;

    // One sequencer tick
    always_comb
    begin
        op_next    = op_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        nack_next  = nack_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;

        if (op_reg == OP_IDLE) begin
            // new command only while idle; unknown codes mean none
            if (cmd.command >= OP_START && cmd.command <= OP_READ) begin
                op_next    = op_t'(cmd.command);
                phase_next = PH_FIRST;
                bit_next   = '0;
                tick_next  = '0;
                if (op_next == OP_WRITE) begin
                    shift_next = cmd.data_byte;
                end
                if (op_next == OP_READ) begin
                    shift_next = '0;
                    nack_next  = cmd.nack_level;
                end
                {scl_next, sda_next} = enter_phase(op_next, phase_next, bit_next,
                                                   shift_next, nack_next,
                                                   scl_next, sda_next);
            end
        end
        else begin
            tick_next = tick_inc;
            if (tick_inc >= len_sat) begin
                tick_next = '0;
                // sample SDA at the end of the high phase
                if (phase_reg == PH_SECOND &&
                    (op_reg == OP_WRITE || op_reg == OP_READ)) begin
                    if (op_reg == OP_WRITE && bit_reg >= LAST_DATA_BIT) begin
                        ack_next = cmd.sda_in;
                    end
                    else if (op_reg == OP_READ && bit_reg < LAST_DATA_BIT) begin
                        shift_next = {shift_reg[6:0], cmd.sda_in};
                    end
                end
                if (phase_reg != PH_THIRD) begin
                    phase_next = phase_reg + 2'd1;
                    {scl_next, sda_next} = enter_phase(op_reg, phase_next, bit_reg,
                                                       shift_next, nack_reg,
                                                       scl_reg, sda_reg);
                end
                else if (op_reg == OP_START || op_reg == OP_STOP) begin
                    op_next    = OP_IDLE;
                    phase_next = PH_FIRST;
                    bit_next   = '0;
                    done_next  = 1'b1;
                end
                else if (bit_reg < LAST_DATA_BIT) begin
                    // next bit of the byte slot
                    if (op_reg == OP_WRITE) begin
                        shift_next = {shift_reg[6:0], 1'b0};
                    end
                    bit_next   = bit_reg + 4'd1;
                    phase_next = PH_FIRST;
                    {scl_next, sda_next} = enter_phase(op_reg, phase_next, bit_next,
                                                       shift_next, nack_reg,
                                                       scl_reg, sda_reg);
                end
                else begin
                    // ack slot over
                    if (op_reg == OP_READ) begin
                        rx_next  = shift_reg;
                        sda_next = 1'b1;
                    end
                    op_next    = OP_IDLE;
                    phase_next = PH_FIRST;
                    bit_next   = '0;
                    done_next  = 1'b1;
                end
            end
        end

        res_next.scl_level = scl_next;
        res_next.sda_level = sda_next;
        res_next.busy_res  = (op_next != OP_IDLE);
        res_next.done_res  = done_next;
        res_next.read_byte = rx_next;
        res_next.ack_seen  = ack_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            setup_reg      <= SETUP_RESET;
            high_reg       <= HIGH_RESET;
            start_stop_reg <= START_STOP_RESET;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                CFG_SETUP:      setup_reg      <= cfg_data;
                CFG_HIGH:       high_reg       <= cfg_data;
                CFG_START_STOP: start_stop_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer state, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op_reg    <= OP_IDLE;
            phase_reg <= PH_FIRST;
            bit_reg   <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            nack_reg  <= 1'b1;
            rx_reg    <= '0;
        end
        else if (accept) begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            nack_reg  <= nack_next;
            rx_reg    <= rx_next;
        end
    end

    // Result valid flags: output register with a one-entry skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || res_ready) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || res_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept) begin
                out_data_reg <= res_next;
            end
        end
        else if (accept) begin
            skid_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
